@@ rtl/env_assignment_line_recognizer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the assignment line recognizer
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ENV_ASSIGNMENT_LINE_RECOGNIZER_UNIT_MACROS_SVH
`define ENV_ASSIGNMENT_LINE_RECOGNIZER_UNIT_MACROS_SVH

// same-cycle implication
`define EALR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define EALR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/ealr_pkg.sv @@
// ----------------------------------------------------------------------------
// ealr_pkg
// Types, byte codes and helper functions of the assignment line recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ealr_pkg;

   typedef enum logic [2:0] {
      PH_NAME_FIRST  = 3'd0,
      PH_NAME        = 3'd1,
      PH_BEFORE_EQ   = 3'd2,
      PH_AFTER_EQ    = 3'd3,
      PH_VALUE_FIRST = 3'd4,
      PH_VALUE       = 3'd5,
      PH_FINISHED    = 3'd6,
      PH_ERROR       = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // space, tab, LF, VT, FF, CR
   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic quote_type quote_code(input logic [7:0] b);
      quote_type q;
      q = QUOTE_NONE;
      if (b == CH_SQUOTE) begin
         q = QUOTE_SINGLE;
      end else if (b == CH_DQUOTE) begin
         q = QUOTE_DOUBLE;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

@@ rtl/env_assignment_line_recognizer_unit.sv @@
// A byte beat updates the parse state in the cycle it is taken; an end
// beat's verdict is registered, in skid if the output is held. Throughput:
// one beat per cycle unless stalled; the single-register phase update is
// the only loop. A two-entry result register (output plus skid) keeps
// req_ open while a verdict waits; req_stall rises only when both are full.
// Reset: synchronous, active high; parse state returns to name-first, no
// quote open, scanning enabled, and both result entries empty.
// ----------------------------------------------------------------------------
// env_assignment_line_recognizer_unit
// Byte-serial recognizer for NAME=VALUE lines; one verdict per end beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "env_assignment_line_recognizer_unit_macros.svh"

module env_assignment_line_recognizer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_byte,
   input  wire logic       req_end_of_line,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_is_assignment
);
   import ealr_pkg::*;

   phase_type phase_ff, phase_in;
   quote_type quote_ff, quote_in;
   logic      stopped_ff, stopped_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_data_ff, rsp_data_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_data_ff, skid_data_in;

   logic      req_accept;
   logic      result_fire;
   logic      out_free;
   logic      verdict;
   logic      byte_ws;
   logic      byte_eq;
   quote_type byte_q;

   assign req_accept  = req_valid && !req_stall;
   assign result_fire = req_accept && req_end_of_line;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign byte_ws = is_ws(req_char_byte);
   assign byte_eq = (req_char_byte == CH_EQUALS);
   assign byte_q  = quote_code(req_char_byte);

   // next parse state
   always_comb begin
      phase_in   = phase_ff;
      quote_in   = quote_ff;
      stopped_in = stopped_ff;
      if (req_accept) begin
         if (req_end_of_line) begin
            phase_in   = PH_NAME_FIRST;
            quote_in   = QUOTE_NONE;
            stopped_in = 1'b0;
         end else if (!stopped_ff && (phase_ff != PH_ERROR)) begin
            if (req_char_byte == CH_NUL) begin
               stopped_in = 1'b1;
            end else begin
               case (phase_ff)
                  PH_NAME_FIRST: begin
                     if (byte_q != QUOTE_NONE) begin
                        phase_in = PH_NAME;
                        quote_in = byte_q;
                     end else if (byte_ws) begin
                        phase_in = PH_BEFORE_EQ;
                     end else if (byte_eq) begin
                        // empty unquoted name
                        phase_in = PH_AFTER_EQ;
                        quote_in = QUOTE_NONE;
                     end else begin
                        phase_in = PH_NAME;
                     end
                  end
                  PH_NAME: begin
                     if (quote_ff != QUOTE_NONE) begin
                        if (byte_q == quote_ff) begin
                           phase_in = PH_BEFORE_EQ;
                        end else if (byte_eq) begin
                           phase_in = PH_ERROR;
                        end
                     end else if (byte_ws) begin
                        phase_in = PH_BEFORE_EQ;
                     end else if (byte_eq) begin
                        phase_in = PH_AFTER_EQ;
                        quote_in = QUOTE_NONE;
                     end
                  end
                  PH_BEFORE_EQ: begin
                     if (byte_eq) begin
                        phase_in = PH_AFTER_EQ;
                        quote_in = QUOTE_NONE;
                     end else if (!byte_ws) begin
                        phase_in = PH_ERROR;
                     end
                  end
                  PH_AFTER_EQ: begin
                     if (!byte_ws) begin
                        phase_in = PH_VALUE;
                        if (byte_q != QUOTE_NONE) begin
                           quote_in = byte_q;
                        end
                     end
                  end
                  PH_VALUE_FIRST: begin
                     phase_in = PH_VALUE;
                     if (byte_q != QUOTE_NONE) begin
                        quote_in = byte_q;
                     end
                  end
                  PH_VALUE: begin
                     if ((quote_ff != QUOTE_NONE) && (byte_q == quote_ff)) begin
                        phase_in = PH_FINISHED;
                     end
                  end
                  PH_FINISHED: begin
                     if (!byte_ws) begin
                        phase_in = PH_ERROR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   // verdict from the current state
   always_comb begin
      verdict = (phase_ff == PH_FINISHED) ||
                ((phase_ff == PH_VALUE) && (quote_ff == QUOTE_NONE));
   end

   // output register with one skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = result_fire;
            rsp_data_in  = verdict;
         end
      end else if (result_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NAME_FIRST;
         quote_ff      <= QUOTE_NONE;
         stopped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         quote_ff      <= quote_in;
         stopped_ff    <= stopped_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_assignment = rsp_data_ff;

   `EALR_ASSERT_IMP(a_skid_behind_out, skid_valid_ff, rsp_valid_ff)
   `EALR_ASSERT_NEXT(a_eol_clears, result_fire,
      (phase_ff == PH_NAME_FIRST) && (quote_ff == QUOTE_NONE) && !stopped_ff)
   `EALR_ASSERT_NEXT(a_stop_freezes, stopped_ff && !result_fire,
      stopped_ff && $stable(phase_ff) && $stable(quote_ff))

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: assignment line recognizer testbench
// Feeds text lines byte by byte and checks each end-of-line verdict against
// a local parse-state tracker. Covers the directed corner cases, a long run
// of mostly well-formed random lines, and a long result-side hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ealr_pkg::*;

   localparam int RANDOM_BEATS = 460;
   localparam int HOLD_LINES   = 15;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_GAP      = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_is_assignment;

   logic pace_stall = 1'b0;
   logic long_hold  = 1'b0;
   assign rsp_stall = pace_stall | long_hold;

   env_assignment_line_recognizer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .req_end_of_line   (req_end_of_line),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_assignment (rsp_is_assignment)
   );

   always #6 clock = ~clock;

   // parse state tracked per line
   phase_type cur_phase = PH_NAME_FIRST;
   quote_type cur_quote = QUOTE_NONE;
   bit        nul_seen  = 1'b0;

   bit         pending_verdicts[$];
   logic [7:0] line_buf[$];

   bit send_idle_on = 1'b1;
   int beats_sent = 0;
   int lines_sent = 0;
   int fail_count = 0;
   int accepted_lines = 0;
   int rejected_lines = 0;
   int in_stall_cycles = 0;

   event hold_go;

   function automatic bit is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic quote_type quote_kind(input logic [7:0] b);
      case (b)
         CH_SQUOTE: return QUOTE_SINGLE;
         CH_DQUOTE: return QUOTE_DOUBLE;
         default:   return QUOTE_NONE;
      endcase
   endfunction

   // one byte through the phase machine; some phases hand the byte on
   function automatic void parse_char(input logic [7:0] b);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (cur_phase)
            PH_NAME_FIRST, PH_VALUE_FIRST: begin
               cur_phase = phase_type'(cur_phase + 3'd1);
               if (quote_kind(b) != QUOTE_NONE) begin
                  cur_quote = quote_kind(b);
               end else begin
                  again = 1'b1;
               end
            end
            PH_NAME, PH_VALUE: begin
               if (cur_quote != QUOTE_NONE) begin
                  if (quote_kind(b) == cur_quote) begin
                     cur_phase = phase_type'(cur_phase + 3'd1);
                  end else if (cur_phase == PH_NAME && b == CH_EQUALS) begin
                     cur_phase = PH_ERROR;
                  end
               end else if (cur_phase == PH_NAME && is_blank(b)) begin
                  cur_phase = PH_BEFORE_EQ;
               end else if (cur_phase == PH_NAME && b == CH_EQUALS) begin
                  cur_phase = PH_BEFORE_EQ;
                  again = 1'b1;
               end
            end
            PH_BEFORE_EQ: begin
               if (b == CH_EQUALS) begin
                  cur_phase = PH_AFTER_EQ;
                  cur_quote = QUOTE_NONE;
               end else if (!is_blank(b)) begin
                  cur_phase = PH_ERROR;
               end
            end
            PH_AFTER_EQ: begin
               if (!is_blank(b)) begin
                  cur_phase = PH_VALUE_FIRST;
                  again = 1'b1;
               end
            end
            PH_FINISHED: begin
               if (!is_blank(b)) begin
                  cur_phase = PH_ERROR;
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void parse_beat(input logic [7:0] b, input logic eol);
      if (eol) begin
         pending_verdicts.push_back((cur_phase == PH_FINISHED) ||
                                    (cur_phase == PH_VALUE && cur_quote == QUOTE_NONE));
         cur_phase = PH_NAME_FIRST;
         cur_quote = QUOTE_NONE;
         nul_seen  = 1'b0;
      end else if (!nul_seen && cur_phase != PH_ERROR) begin
         if (b == CH_NUL) begin
            nul_seen = 1'b1;
         end else begin
            parse_char(b);
         end
      end
   endfunction

   function automatic logic [7:0] body_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(33, 126));
      end while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_EQUALS);
      return c;
   endfunction

   function automatic logic [7:0] blank_char();
      int k;
      k = $urandom_range(9, 14);
      return (k == 14) ? CH_SPACE : 8'(k);
   endfunction

   // name or value: unquoted, single or double quoted, maybe left open
   function automatic void add_field();
      quote_type  q;
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0:       q = QUOTE_NONE;
         1:       q = QUOTE_SINGLE;
         default: q = QUOTE_DOUBLE;
      endcase
      if (q != QUOTE_NONE) begin
         line_buf.push_back(q == QUOTE_SINGLE ? CH_SQUOTE : CH_DQUOTE);
      end
      repeat ($urandom_range(0, 4)) begin
         c = body_char();
         if (q != QUOTE_NONE) begin
            case ($urandom_range(0, 9))
               0:       c = CH_EQUALS;
               1:       c = blank_char();
               2:       c = (q == QUOTE_SINGLE) ? CH_DQUOTE : CH_SQUOTE;
               default: ;
            endcase
         end
         line_buf.push_back(c);
      end
      if (q != QUOTE_NONE && $urandom_range(0, 7) != 0) begin
         line_buf.push_back(q == QUOTE_SINGLE ? CH_SQUOTE : CH_DQUOTE);
      end
   endfunction

   function automatic void build_line();
      line_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_field();
         repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
         if ($urandom_range(0, 11) != 0) begin
            line_buf.push_back(CH_EQUALS);
         end
         repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
         add_field();
         repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
         if ($urandom_range(0, 5) == 0) begin
            line_buf.push_back(body_char());
         end
         if (line_buf.size() != 0 && $urandom_range(0, 5) == 0) begin
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 9) == 0) begin
            line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
         end
      end
   endfunction

   function automatic void load_text(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) begin
         line_buf.push_back(s[i]);
      end
   endfunction

   // called in the step of the previous acceptance (or right after reset)
   task automatic send_beat(input logic [7:0] b, input logic eol);
      int gap;
      gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= b;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_beat(b, eol);
      beats_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) begin
         send_beat(line_buf[i], 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      lines_sent++;
   endtask

   task automatic test_directed_lines();
      send_idle_on = 1'b1;
      load_text("=1");          // empty unquoted name
      send_line();
      load_text("a=");          // empty value
      send_line();
      load_text("''=\"\"");     // quoted empty name, quoted empty value
      send_line();
      load_text("\"=");         // '=' inside a quoted name
      send_line();
      load_text("='");          // opening quote as the last byte
      send_line();
      line_buf.delete();        // bare end beat
      send_line();
      load_text("v=");          // zero byte stops the scan
      line_buf.push_back(8'hFF);
      line_buf.push_back(CH_NUL);
      line_buf.push_back(CH_SQUOTE);
      send_line();
   endtask

   task automatic test_random_lines();
      int first_beat;
      first_beat = beats_sent;
      while (beats_sent - first_beat < RANDOM_BEATS) begin
         send_idle_on = ($urandom_range(0, 3) != 0);
         build_line();
         send_line();
      end
   endtask

   // result side blocked for a long stretch while lines keep coming
   task automatic test_backpressure();
      send_idle_on = 1'b0;
      -> hold_go;
      repeat (HOLD_LINES) begin
         build_line();
         send_line();
      end
   endtask

   initial begin : long_hold_proc
      forever begin
         @(hold_go);
         long_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   // result-side pacing: stalls before each beat, in bursts of on and off
   initial begin : rsp_pacing
      int  hold;
      int  mode_left;
      bit  stalls_on;
      mode_left = 0;
      stalls_on = 1'b1;
      @(posedge clock);
      forever begin
         if (mode_left == 0) begin
            stalls_on = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(1, 20);
         end
         mode_left--;
         hold = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
         if (hold > 0) begin
            pace_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         pace_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : verdict_check
      bit want;
      if (!reset) begin
         if (req_valid && req_stall) begin
            in_stall_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: verdict beat with none pending: expected none, actual %0b",
                        $time, rsp_is_assignment);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_is_assignment !== want) begin
                  fail_count++;
                  $display("%0t: is_assignment mismatch: expected %0b, actual %0b",
                           $time, want, rsp_is_assignment);
               end else if (want) begin
                  accepted_lines++;
               end else begin
                  rejected_lines++;
               end
            end
         end
      end
   end

   initial begin : run
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_lines();
      test_random_lines();
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d lines in %0d beats; %0d verdicts matched as settings, %0d as not.",
               lines_sent, beats_sent, accepted_lines, rejected_lines);
      $display("Input side was held off for %0d cycles during result-side blocking.",
               in_stall_cycles);
      if (fail_count == 0) begin
         $display("env_assignment_line_recognizer_unit: match");
      end else begin
         $display("env_assignment_line_recognizer_unit: mismatch");
      end
      $finish;
   end

   // worst case is under 900 beats, each with its idle gap, plus the hold-off
   initial begin : watchdog
      #4_000_000;
      $display("env_assignment_line_recognizer_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/ealr_pkg.sv
rtl/env_assignment_line_recognizer_unit.sv
bench/tb_top.sv
